// ===== hdl/barometric_pressure_compensation_top_assert.svh =====
// Assertion macros for the pressure compensation block.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BPC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpc: %s failed", "lbl");

// Next-cycle implication, checked out of reset.
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpc: %s failed", "lbl");

`endif

// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants and helpers for the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int unsigned DIV_BITS = 32;

   typedef enum logic [1:0] {
      CSR_CAL_SIGNED_A   = 2'd0,
      CSR_CAL_UNSIGNED_A = 2'd1,
      CSR_CAL_B_PAIR     = 2'd2,
      CSR_CAL_M_PAIR     = 2'd3
   } csr_index_type;

   // signed divide by 2^k, truncating toward zero
   function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                     input int unsigned k);
      logic signed [31:0] bias;
      bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (a + bias) >>> k;
   endfunction

endpackage

// ===== hdl/bpc_udiv.sv =====
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_udiv
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic [31:0] quo
);

   // entry i holds the operands entering stage i; the last stage only passes q
   logic [31:0] n_ff [1:DIV_BITS-1];
   logic [31:0] d_ff [1:DIV_BITS-1];
   logic [31:0] r_ff [1:DIV_BITS-1];
   logic [31:0] q_ff [1:DIV_BITS];

   for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
      logic [31:0] n_cur, d_cur, r_cur, q_cur;
      logic [32:0] sh;
      logic        ge;
      logic [32:0] diff;

      if (i == 0) begin : g_first
         assign n_cur = num;
         assign d_cur = den;
         assign r_cur = '0;
         assign q_cur = '0;
      end else begin : g_next
         assign n_cur = n_ff[i];
         assign d_cur = d_ff[i];
         assign r_cur = r_ff[i];
         assign q_cur = q_ff[i];
      end

      assign sh   = {r_cur, n_cur[31]};
      assign diff = sh - {1'b0, d_cur};
      assign ge   = (sh >= {1'b0, d_cur});

      always_ff @(posedge clock) begin
         if (adv) q_ff[i+1] <= {q_cur[30:0], ge};
      end

      if (i < DIV_BITS-1) begin : g_fwd
         always_ff @(posedge clock) begin
            if (adv) begin
               n_ff[i+1] <= {n_cur[30:0], 1'b0};
               d_ff[i+1] <= d_cur;
               r_ff[i+1] <= ge ? diff[31:0] : sh[31:0];
            end
         end
      end
   end

   assign quo = q_ff[DIV_BITS];

endmodule

// ===== hdl/barometric_pressure_compensation_top.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// BMP180-style temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   tvalid/tready        tdata: raw_temperature, raw_pressure
//  rsp_     out  tvalid/tready        tdata: pressure_pa, temperature_dc; tuser: error
//  csr_     in   we                   addr, wdata
//
// One request per cycle while the output is not stalled; the pipeline has 2 * 32
// divider stages, from the two bit-per-stage dividers, plus 13 datapath stages.
// Synchronous reset clears calibration and all valid bits.
// The whole pipeline holds while a result waits and rsp_tready is low.
module barometric_pressure_compensation_top
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // raw_temperature[15:0], raw_pressure[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pressure_pa[31:0], temperature_dc[47:32]
   output logic        rsp_tuser,   // divide_error
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [47:0] csr_wdata
);

`include "barometric_pressure_compensation_top_assert.svh"

   logic [47:0] cal_sa_ff, cal_ua_ff;
   logic [31:0] cal_b_ff, cal_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_sa_ff <= '0;
         cal_ua_ff <= '0;
         cal_b_ff  <= '0;
         cal_m_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CAL_SIGNED_A:   cal_sa_ff <= csr_wdata;
            CSR_CAL_UNSIGNED_A: cal_ua_ff <= csr_wdata;
            CSR_CAL_B_PAIR:     cal_b_ff  <= csr_wdata[31:0];
            CSR_CAL_M_PAIR:     cal_m_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic        [15:0] ac4, ac5, ac6;
   assign ac1 = cal_sa_ff[47:32];
   assign ac2 = cal_sa_ff[31:16];
   assign ac3 = cal_sa_ff[15:0];
   assign ac4 = cal_ua_ff[47:32];
   assign ac5 = cal_ua_ff[31:16];
   assign ac6 = cal_ua_ff[15:0];
   assign b1  = cal_b_ff[31:16];
   assign b2  = cal_b_ff[15:0];
   assign mc  = cal_m_ff[31:16];
   assign md  = cal_m_ff[15:0];

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---- stage 1: x1 from UT
   logic signed [16:0] dut;
   logic signed [33:0] p1;
   logic signed [31:0] x1_in;
   logic               v1_ff;
   logic signed [31:0] x1_ff;
   logic        [15:0] up1_ff;
   assign dut   = $signed({1'b0, req_tdata[15:0]}) - $signed({1'b0, ac6});
   assign p1    = dut * $signed({1'b0, ac5});
   assign x1_in = sdiv_pow2(p1[31:0], 15);

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
      if (adv) begin
         x1_ff  <= x1_in;
         up1_ff <= req_tdata[31:16];
      end
   end

   // ---- stage 2: divider operands
   logic signed [31:0] d_in, num2;
   logic        [31:0] dmag_ff, nmag_ff;
   logic               v2_ff, neg2_ff, err2_ff;
   logic signed [31:0] x1b_ff;
   logic        [15:0] up2_ff;
   assign d_in = x1_ff + 32'(md);
   assign num2 = 32'(mc) <<< 11;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         dmag_ff <= d_in[31] ? 32'(-d_in) : d_in;
         nmag_ff <= num2[31] ? 32'(-num2) : num2;
         neg2_ff <= d_in[31] ^ num2[31];
         err2_ff <= (d_in == 32'sd0);
         x1b_ff  <= x1_ff;
         up2_ff  <= up1_ff;
      end
   end

   logic [31:0] q1;
   bpc_udiv u_div_t (
      .clock(clock), .adv(adv), .num(nmag_ff), .den(dmag_ff), .quo(q1)
   );

   logic               dv_a_ff   [DIV_BITS];
   logic               dneg_a_ff [DIV_BITS];
   logic               derr_a_ff [DIV_BITS];
   logic signed [31:0] dx1_a_ff  [DIV_BITS];
   logic        [15:0] dup_a_ff  [DIV_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_BITS; i++) dv_a_ff[i] <= 1'b0;
      end else if (adv) begin
         dv_a_ff[0] <= v2_ff;
         for (int i = 1; i < DIV_BITS; i++) dv_a_ff[i] <= dv_a_ff[i-1];
      end
      if (adv) begin
         dneg_a_ff[0] <= neg2_ff;
         derr_a_ff[0] <= err2_ff;
         dx1_a_ff[0]  <= x1b_ff;
         dup_a_ff[0]  <= up2_ff;
         for (int i = 1; i < DIV_BITS; i++) begin
            dneg_a_ff[i] <= dneg_a_ff[i-1];
            derr_a_ff[i] <= derr_a_ff[i-1];
            dx1_a_ff[i]  <= dx1_a_ff[i-1];
            dup_a_ff[i]  <= dup_a_ff[i-1];
         end
      end
   end

   // ---- stage 3: B5
   logic signed [31:0] x2_t;
   logic               v3_ff, err3_ff;
   logic signed [31:0] b5_ff;
   logic        [15:0] up3_ff;
   assign x2_t = dneg_a_ff[DIV_BITS-1] ? 32'(-$signed(q1)) : $signed(q1);

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= dv_a_ff[DIV_BITS-1];
      if (adv) begin
         b5_ff   <= dx1_a_ff[DIV_BITS-1] + x2_t;
         err3_ff <= derr_a_ff[DIV_BITS-1];
         up3_ff  <= dup_a_ff[DIV_BITS-1];
      end
   end

   // ---- stage 4: T and B6
   logic signed [31:0] t_full;
   logic signed [15:0] t_sat;
   logic               v4_ff, err4_ff;
   logic signed [31:0] b6_ff;
   logic signed [15:0] t4_ff;
   logic        [15:0] up4_ff;
   assign t_full = sdiv_pow2(b5_ff + 32'sd8, 4);
   always_comb begin
      if (t_full > 32'sd32767)       t_sat = 16'sh7fff;
      else if (t_full < -32'sd32768) t_sat = 16'sh8000;
      else                           t_sat = t_full[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         b6_ff   <= b5_ff - 32'sd4000;
         t4_ff   <= t_sat;
         err4_ff <= err3_ff;
         up4_ff  <= up3_ff;
      end
   end

   // ---- stage 5: B6 products
   logic signed [63:0] b6sq;
   logic signed [47:0] ac2b6, ac3b6;
   logic               v5_ff, err5_ff;
   logic signed [31:0] b6sq_ff, ac2b6_ff, ac3b6_ff;
   logic signed [15:0] t5_ff;
   logic        [15:0] up5_ff;
   assign b6sq  = b6_ff * b6_ff;
   assign ac2b6 = ac2 * b6_ff;
   assign ac3b6 = ac3 * b6_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         b6sq_ff  <= b6sq[31:0];
         ac2b6_ff <= ac2b6[31:0];
         ac3b6_ff <= ac3b6[31:0];
         t5_ff    <= t4_ff;
         err5_ff  <= err4_ff;
         up5_ff   <= up4_ff;
      end
   end

   // ---- stage 6: scale
   logic               v6_ff, err6_ff;
   logic signed [31:0] sq_ff, x2b_ff, x1c_ff;
   logic signed [15:0] t6_ff;
   logic        [15:0] up6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         sq_ff   <= sdiv_pow2(b6sq_ff, 12);
         x2b_ff  <= sdiv_pow2(ac2b6_ff, 11);
         x1c_ff  <= sdiv_pow2(ac3b6_ff, 13);
         t6_ff   <= t5_ff;
         err6_ff <= err5_ff;
         up6_ff  <= up5_ff;
      end
   end

   // ---- stage 7: b1, b2 products
   logic signed [47:0] b2sq, b1sq;
   logic               v7_ff, err7_ff;
   logic signed [31:0] b2sq_ff, b1sq_ff, x2b7_ff, x1c7_ff;
   logic signed [15:0] t7_ff;
   logic        [15:0] up7_ff;
   assign b2sq = b2 * sq_ff;
   assign b1sq = b1 * sq_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
      if (adv) begin
         b2sq_ff <= b2sq[31:0];
         b1sq_ff <= b1sq[31:0];
         x2b7_ff <= x2b_ff;
         x1c7_ff <= x1c_ff;
         t7_ff   <= t6_ff;
         err7_ff <= err6_ff;
         up7_ff  <= up6_ff;
      end
   end

   // ---- stage 8: B3 and the B4 factor
   logic signed [31:0] x3b, x3c;
   logic               v8_ff, err8_ff;
   logic signed [31:0] b3_ff, u8_ff;
   logic signed [15:0] t8_ff;
   logic        [15:0] up8_ff;
   assign x3b = sdiv_pow2(b2sq_ff, 11) + x2b7_ff;
   assign x3c = sdiv_pow2(x1c7_ff + sdiv_pow2(b1sq_ff, 16) + 32'sd2, 2);

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
      if (adv) begin
         b3_ff   <= sdiv_pow2((32'(ac1) <<< 2) + x3b + 32'sd2, 2);
         u8_ff   <= x3c + 32'sd32768;
         t8_ff   <= t7_ff;
         err8_ff <= err7_ff;
         up8_ff  <= up7_ff;
      end
   end

   // ---- stage 9: B4 and B7
   logic [31:0] b4p;
   logic [47:0] b7p;
   logic [31:0] up_m_b3;
   logic        v9_ff, err9_ff;
   logic [31:0] b4_ff, b7_ff;
   logic signed [15:0] t9_ff;
   // product wraps at 32 bits before the divide by 2^15
   assign b4p     = 32'(ac4 * $unsigned(u8_ff));
   assign up_m_b3 = {16'd0, up8_ff} - $unsigned(b3_ff);
   assign b7p     = up_m_b3 * 16'd50000;

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (adv) v9_ff <= v8_ff;
      if (adv) begin
         b4_ff   <= {15'd0, b4p[31:15]};
         b7_ff   <= b7p[31:0];
         t9_ff   <= t8_ff;
         err9_ff <= err8_ff;
      end
   end

   // ---- stage 10: pressure divider operands
   logic        v10_ff, err10_ff, hi10_ff;
   logic [31:0] num10_ff, den10_ff;
   logic signed [15:0] t10_ff;

   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (adv) v10_ff <= v9_ff;
      if (adv) begin
         hi10_ff  <= b7_ff[31];
         num10_ff <= b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
         den10_ff <= b4_ff;
         err10_ff <= err9_ff || (b4_ff == 32'd0);
         t10_ff   <= t9_ff;
      end
   end

   logic [31:0] q2;
   bpc_udiv u_div_p (
      .clock(clock), .adv(adv), .num(num10_ff), .den(den10_ff), .quo(q2)
   );

   logic               dv_b_ff  [DIV_BITS];
   logic               dhi_b_ff [DIV_BITS];
   logic               derr_b_ff[DIV_BITS];
   logic signed [15:0] dt_b_ff  [DIV_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_BITS; i++) dv_b_ff[i] <= 1'b0;
      end else if (adv) begin
         dv_b_ff[0] <= v10_ff;
         for (int i = 1; i < DIV_BITS; i++) dv_b_ff[i] <= dv_b_ff[i-1];
      end
      if (adv) begin
         dhi_b_ff[0]  <= hi10_ff;
         derr_b_ff[0] <= err10_ff;
         dt_b_ff[0]   <= t10_ff;
         for (int i = 1; i < DIV_BITS; i++) begin
            dhi_b_ff[i]  <= dhi_b_ff[i-1];
            derr_b_ff[i] <= derr_b_ff[i-1];
            dt_b_ff[i]   <= dt_b_ff[i-1];
         end
      end
   end

   // ---- stage 11: p and its products
   logic signed [31:0] p_raw, pd;
   logic signed [63:0] pdsq;
   logic signed [47:0] p7357;
   logic               v11_ff, err11_ff;
   logic signed [31:0] p11_ff, pdsq_ff, p7357_ff;
   logic signed [15:0] t11_ff;
   assign p_raw = dhi_b_ff[DIV_BITS-1] ? {q2[30:0], 1'b0} : q2;
   assign pd    = sdiv_pow2(p_raw, 8);
   assign pdsq  = pd * pd;
   assign p7357 = p_raw * -16'sd7357;

   always_ff @(posedge clock) begin
      if (reset) v11_ff <= 1'b0;
      else if (adv) v11_ff <= dv_b_ff[DIV_BITS-1];
      if (adv) begin
         p11_ff   <= p_raw;
         pdsq_ff  <= pdsq[31:0];
         p7357_ff <= p7357[31:0];
         err11_ff <= derr_b_ff[DIV_BITS-1];
         t11_ff   <= dt_b_ff[DIV_BITS-1];
      end
   end

   // ---- stage 12: x1 * 3038
   logic signed [47:0] m3038;
   logic               v12_ff, err12_ff;
   logic signed [31:0] p12_ff, m12_ff, x2p_ff;
   logic signed [15:0] t12_ff;
   assign m3038 = pdsq_ff * 16'sd3038;

   always_ff @(posedge clock) begin
      if (reset) v12_ff <= 1'b0;
      else if (adv) v12_ff <= v11_ff;
      if (adv) begin
         p12_ff   <= p11_ff;
         m12_ff   <= m3038[31:0];
         x2p_ff   <= sdiv_pow2(p7357_ff, 16);
         err12_ff <= err11_ff;
         t12_ff   <= t11_ff;
      end
   end

   // ---- stage 13: final pressure, output register
   logic signed [31:0] p_fin;
   logic               v13_ff, err13_ff;
   logic signed [31:0] p13_ff;
   logic signed [15:0] t13_ff;
   assign p_fin = p12_ff
                + sdiv_pow2(sdiv_pow2(m12_ff, 16) + x2p_ff + 32'sd3791, 4);

   always_ff @(posedge clock) begin
      if (reset) v13_ff <= 1'b0;
      else if (adv) v13_ff <= v12_ff;
      if (adv) begin
         p13_ff   <= err12_ff ? 32'sd0 : p_fin;
         t13_ff   <= err12_ff ? 16'sd0 : t12_ff;
         err13_ff <= err12_ff;
      end
   end

   assign rsp_tvalid = v13_ff;
   assign rsp_tdata  = {t13_ff, p13_ff};
   assign rsp_tuser  = err13_ff;

   `BPC_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 48'd0)
   `BPC_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BPC_ASSERT_NOW(a_ready, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))

endmodule
